### hw/rtl/cpot_pkg.sv
// Shared types and constants for the collider pair overlap test.
// Used by cpot_seg_near and collider_pair_overlap_test_top; no dependencies.
package cpot_pkg;

	localparam int COORD_BITS  = 21;
	localparam int FRAC_BITS   = 8;
	localparam int T_BITS      = 20;
	localparam int RANGE_UNITS = 10000;
	localparam int PT_W        = 63;
	localparam int RAD_W       = 20;
	localparam int BEST_W      = 64;
	localparam int RSUM_W      = RAD_W + 1;
	localparam int RSQ_W       = 2 * RSUM_W;
	// number of register stages in the segment-nearest unit
	localparam int SEG_LAT     = T_BITS + 9;

	localparam logic [1:0] MODE_SPHERE     = 2'd0;
	localparam logic [1:0] MODE_CAP_SPHERE = 2'd1;
	localparam logic [1:0] MODE_CAP_CAP    = 2'd2;

	typedef struct packed {
		logic [1:0]       mode;
		logic [PT_W-1:0]  a_start;
		logic [PT_W-1:0]  a_end;
		logic [RAD_W-1:0] a_radius;
		logic [PT_W-1:0]  b_start;
		logic [PT_W-1:0]  b_end;
		logic [RAD_W-1:0] b_radius;
	} cpot_in_t;

	typedef struct packed {
		logic            hit;
		logic            near_a_valid;
		logic [PT_W-1:0] near_a;
		logic            near_b_valid;
		logic [PT_W-1:0] near_b;
	} cpot_out_t;

	// per-item data carried beside the segment units
	typedef struct packed {
		logic [1:0]        mode;
		logic              par;
		logic              hit0;
		logic [BEST_W-1:0] par_best;
		logic [PT_W-1:0]   par_na;
		logic [PT_W-1:0]   par_nb;
		logic [RSQ_W-1:0]  rsq;
	} cpot_side_t;

endpackage

### hw/rtl/cpot_seg_near.sv
// Pipelined nearest point on segment s..e to point p, with squared distance.
// Depends on cpot_pkg; cpot_pkg::SEG_LAT register stages, one item per cycle while en is high.
module cpot_seg_near #(
	parameter int COORD_BITS = cpot_pkg::COORD_BITS
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [cpot_pkg::PT_W-1:0]  s_pt,
	input  logic [cpot_pkg::PT_W-1:0]  e_pt,
	input  logic [cpot_pkg::PT_W-1:0]  p_pt,
	output logic [cpot_pkg::PT_W-1:0]  near_pt,
	output logic [cpot_pkg::BEST_W-1:0] dist_sq
);

	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int PW = 2 * DW;
	localparam int QW = 2 * CB + 2;
	localparam int NW = 2 * CB + 3;
	localparam int RW = QW + 1;
	localparam int TB = cpot_pkg::T_BITS;
	localparam int MW = CB + TB;

	localparam logic [1:0] SEL_S = 2'd0;
	localparam logic [1:0] SEL_E = 2'd1;
	localparam logic [1:0] SEL_P = 2'd2;

	logic signed [CB-1:0] s_u [3];
	logic signed [CB-1:0] e_u [3];
	logic signed [CB-1:0] p_u [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			s_u[k] = s_pt[k*CB +: CB];
			e_u[k] = e_pt[k*CB +: CB];
			p_u[k] = p_pt[k*CB +: CB];
		end
	end

	// stage 1: direction and offset
	logic signed [CB-1:0] s_s1 [3], e_s1 [3], p_s1 [3];
	logic signed [DW-1:0] d_s1 [3], w_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				s_s1[k] <= s_u[k];
				e_s1[k] <= e_u[k];
				p_s1[k] <= p_u[k];
				d_s1[k] <= $signed({e_u[k][CB-1], e_u[k]}) - $signed({s_u[k][CB-1], s_u[k]});
				w_s1[k] <= $signed({p_u[k][CB-1], p_u[k]}) - $signed({s_u[k][CB-1], s_u[k]});
			end
		end
	end

	// stage 2: products
	logic signed [CB-1:0] s_s2 [3], e_s2 [3], p_s2 [3];
	logic signed [DW-1:0] d_s2 [3];
	logic signed [PW-1:0] dd_s2 [3], dw_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				s_s2[k]  <= s_s1[k];
				e_s2[k]  <= e_s1[k];
				p_s2[k]  <= p_s1[k];
				d_s2[k]  <= d_s1[k];
				dd_s2[k] <= d_s1[k] * d_s1[k];
				dw_s2[k] <= d_s1[k] * w_s1[k];
			end
		end
	end

	// stage 3: dot sums
	logic signed [CB-1:0] s_s3 [3], e_s3 [3], p_s3 [3];
	logic signed [DW-1:0] d_s3 [3];
	logic        [QW-1:0] q_s3;
	logic signed [NW-1:0] n_s3;
	logic signed [NW-1:0] qsum, nsum;

	always_comb begin
		qsum = NW'(dd_s2[0]) + NW'(dd_s2[1]) + NW'(dd_s2[2]);
		nsum = NW'(dw_s2[0]) + NW'(dw_s2[1]) + NW'(dw_s2[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				s_s3[k] <= s_s2[k];
				e_s3[k] <= e_s2[k];
				p_s3[k] <= p_s2[k];
				d_s3[k] <= d_s2[k];
			end
			q_s3 <= qsum[QW-1:0];
			n_s3 <= nsum;
		end
	end

	// stage 4 (index 0) and one quotient bit per divider stage
	logic signed [CB-1:0] s_sv [TB+1][3];
	logic signed [CB-1:0] e_sv [TB+1][3];
	logic signed [CB-1:0] p_sv [TB+1][3];
	logic signed [DW-1:0] d_sv [TB+1][3];
	logic        [1:0]    sel_sv [TB+1];
	logic        [RW-1:0] rem_sv [TB+1];
	logic        [QW-1:0] q_sv [TB+1];
	logic        [TB-1:0] t_sv [TB+1];
	logic        [1:0]    sel_n;

	always_comb begin
		if (q_s3 == '0 || n_s3 <= 0) begin
			sel_n = SEL_S;
		end else if (n_s3 >= $signed({1'b0, q_s3})) begin
			sel_n = SEL_E;
		end else begin
			sel_n = SEL_P;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_sv[0]   <= s_s3;
			e_sv[0]   <= e_s3;
			p_sv[0]   <= p_s3;
			d_sv[0]   <= d_s3;
			sel_sv[0] <= sel_n;
			rem_sv[0] <= $unsigned(n_s3);
			q_sv[0]   <= q_s3;
			t_sv[0]   <= '0;
		end
	end

	for (genvar j = 0; j < TB; j++) begin : g_div
		logic [RW-1:0] rem2;
		logic          ge;

		always_comb begin
			rem2 = {rem_sv[j][RW-2:0], 1'b0};
			ge   = rem2 >= {1'b0, q_sv[j]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				s_sv[j+1]   <= s_sv[j];
				e_sv[j+1]   <= e_sv[j];
				p_sv[j+1]   <= p_sv[j];
				d_sv[j+1]   <= d_sv[j];
				sel_sv[j+1] <= sel_sv[j];
				q_sv[j+1]   <= q_sv[j];
				rem_sv[j+1] <= ge ? (rem2 - {1'b0, q_sv[j]}) : rem2;
				if (TB > 1) begin
					t_sv[j+1] <= {t_sv[j][TB-2:0], ge};
				end else begin
					t_sv[j+1] <= TB'(ge);
				end
			end
		end
	end

	// scale |d| by t
	logic signed [CB-1:0] s_sm [3], e_sm [3], p_sm [3];
	logic        [MW-1:0] prod_sm [3];
	logic                 neg_sm [3];
	logic        [1:0]    sel_sm;
	logic signed [DW-1:0] dneg [3];
	logic        [CB-1:0] mag [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dneg[k] = -d_sv[TB][k];
			mag[k]  = d_sv[TB][k][DW-1] ? dneg[k][CB-1:0] : d_sv[TB][k][CB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				s_sm[k]    <= s_sv[TB][k];
				e_sm[k]    <= e_sv[TB][k];
				p_sm[k]    <= p_sv[TB][k];
				prod_sm[k] <= MW'(mag[k]) * MW'(t_sv[TB]);
				neg_sm[k]  <= d_sv[TB][k][DW-1];
			end
			sel_sm <= sel_sv[TB];
		end
	end

	// pick the nearest point
	logic signed [CB-1:0] near_so [3], p_so [3];
	logic signed [DW-1:0] r_full [3];
	logic signed [CB-1:0] near_n [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (neg_sm[k]) begin
				r_full[k] = $signed({s_sm[k][CB-1], s_sm[k]}) -
					$signed({1'b0, prod_sm[k][MW-1:TB]});
			end else begin
				r_full[k] = $signed({s_sm[k][CB-1], s_sm[k]}) +
					$signed({1'b0, prod_sm[k][MW-1:TB]});
			end
			case (sel_sm)
				SEL_S:   near_n[k] = s_sm[k];
				SEL_E:   near_n[k] = e_sm[k];
				default: near_n[k] = r_full[k][CB-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_so <= near_n;
			p_so    <= p_sm;
		end
	end

	// distance: difference, squares, sum
	logic signed [CB-1:0] near_sf [3], near_sq [3];
	logic signed [DW-1:0] df_sf [3];
	logic signed [PW-1:0] sq_sq [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				near_sf[k] <= near_so[k];
				df_sf[k]   <= $signed({near_so[k][CB-1], near_so[k]}) -
					$signed({p_so[k][CB-1], p_so[k]});
				near_sq[k] <= near_sf[k];
				sq_sq[k]   <= df_sf[k] * df_sf[k];
			end
		end
	end

	logic [QW-1:0]             dsum;
	logic [cpot_pkg::PT_W-1:0] pack_n;

	always_comb begin
		dsum = QW'($unsigned(sq_sq[0])) + QW'($unsigned(sq_sq[1])) +
			QW'($unsigned(sq_sq[2]));
		pack_n = '0;
		for (int k = 0; k < 3; k++) begin
			pack_n[k*CB +: CB] = near_sq[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_sq <= cpot_pkg::BEST_W'(dsum);
			near_pt <= pack_n;
		end
	end

endmodule

### hw/rtl/collider_pair_overlap_test_top.sv
// Collider pair overlap test, top level: side path, delay line, candidate merge.
// Depends on cpot_pkg and cpot_seg_near.
//
//  channel  | signals                          | direction | payload
//  ---------+----------------------------------+-----------+------------
//  pair     | pair_valid, pair_ready, pair     | in        | cpot_in_t
//  result   | result_valid, result_ready, result | out     | cpot_out_t
//
// One pair per cycle while pair_ready is high; each result passes the four
// segment units (a 20-stage restoring divider in each), merge 1, merge 2 and
// the output register. Reset clears only the stage valid bits. A stall on the
// result side freezes every stage at once, so nothing is lost or repeated;
// pair_ready stays high while the result register is empty or being taken.
module collider_pair_overlap_test_top #(
	parameter int COORD_BITS = cpot_pkg::COORD_BITS,
	parameter int FRAC_BITS  = cpot_pkg::FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pair_valid,
	output logic                pair_ready,
	input  cpot_pkg::cpot_in_t  pair,
	output logic                result_valid,
	input  logic                result_ready,
	output cpot_pkg::cpot_out_t result
);

	localparam int CB  = COORD_BITS;
	localparam int DW  = CB + 1;
	localparam int PW  = 2 * DW;
	localparam int QW  = 2 * CB + 2;
	localparam int PTW = cpot_pkg::PT_W;
	localparam int BW  = cpot_pkg::BEST_W;
	localparam int DL  = cpot_pkg::SEG_LAT - 4;
	localparam logic [BW-1:0] LIM    = BW'(cpot_pkg::RANGE_UNITS) << FRAC_BITS;
	localparam logic [BW-1:0] LIM_SQ = LIM * LIM;
	localparam logic [PTW-1:0] PT_MASK = {{(PTW - 3 * CB){1'b0}}, {(3 * CB){1'b1}}};

	logic en, acc;

	// whole pipeline advances unless the result register holds an untaken item
	assign en         = !result_valid || result_ready;
	assign pair_ready = en;
	assign acc        = pair_valid && en;

	// four projections: A ends onto B, B ends onto A
	logic [PTW-1:0] up_pt [4];
	logic [BW-1:0]  up_d [4];

	cpot_seg_near #(.COORD_BITS(CB)) u_seg0 (
		.clk(clk), .en(en), .s_pt(pair.b_start), .e_pt(pair.b_end), .p_pt(pair.a_start),
		.near_pt(up_pt[0]), .dist_sq(up_d[0])
	);
	cpot_seg_near #(.COORD_BITS(CB)) u_seg1 (
		.clk(clk), .en(en), .s_pt(pair.b_start), .e_pt(pair.b_end), .p_pt(pair.a_end),
		.near_pt(up_pt[1]), .dist_sq(up_d[1])
	);
	cpot_seg_near #(.COORD_BITS(CB)) u_seg2 (
		.clk(clk), .en(en), .s_pt(pair.a_start), .e_pt(pair.a_end), .p_pt(pair.b_start),
		.near_pt(up_pt[2]), .dist_sq(up_d[2])
	);
	cpot_seg_near #(.COORD_BITS(CB)) u_seg3 (
		.clk(clk), .en(en), .s_pt(pair.a_start), .e_pt(pair.a_end), .p_pt(pair.b_end),
		.near_pt(up_pt[3]), .dist_sq(up_d[3])
	);

	// side path stage 1: segment directions and endpoint pair differences
	logic signed [CB-1:0] a0 [3], a1 [3], b0 [3], b1 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a0[k] = pair.a_start[k*CB +: CB];
			a1[k] = pair.a_end[k*CB +: CB];
			b0[k] = pair.b_start[k*CB +: CB];
			b1[k] = pair.b_end[k*CB +: CB];
		end
	end

	logic                       v_s1;
	logic [1:0]                 mode_s1;
	logic [PTW-1:0]             a0_s1, a1_s1, b0_s1, b1_s1;
	logic [cpot_pkg::RSUM_W-1:0] rsum_s1;
	logic signed [DW-1:0]       da_s1 [3], db_s1 [3];
	logic signed [DW-1:0]       pd_s1 [4][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= pair.mode;
			a0_s1   <= pair.a_start;
			a1_s1   <= pair.a_end;
			b0_s1   <= pair.b_start;
			b1_s1   <= pair.b_end;
			rsum_s1 <= cpot_pkg::RSUM_W'(pair.a_radius) + cpot_pkg::RSUM_W'(pair.b_radius);
			for (int k = 0; k < 3; k++) begin
				da_s1[k]    <= $signed({a1[k][CB-1], a1[k]}) - $signed({a0[k][CB-1], a0[k]});
				db_s1[k]    <= $signed({b0[k][CB-1], b0[k]}) - $signed({b1[k][CB-1], b1[k]});
				pd_s1[0][k] <= $signed({a0[k][CB-1], a0[k]}) - $signed({b0[k][CB-1], b0[k]});
				pd_s1[1][k] <= $signed({a0[k][CB-1], a0[k]}) - $signed({b1[k][CB-1], b1[k]});
				pd_s1[2][k] <= $signed({a1[k][CB-1], a1[k]}) - $signed({b0[k][CB-1], b0[k]});
				pd_s1[3][k] <= $signed({a1[k][CB-1], a1[k]}) - $signed({b1[k][CB-1], b1[k]});
			end
		end
	end

	// stage 2: cross-product terms, squares, radius sum squared
	logic                       v_s2;
	logic [1:0]                 mode_s2;
	logic [PTW-1:0]             a0_s2, a1_s2, b0_s2, b1_s2;
	logic [cpot_pkg::RSQ_W-1:0] rsq_s2;
	logic signed [PW-1:0]       cp_s2 [6];
	logic signed [PW-1:0]       psq_s2 [4][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2  <= mode_s1;
			a0_s2    <= a0_s1;
			a1_s2    <= a1_s1;
			b0_s2    <= b0_s1;
			b1_s2    <= b1_s1;
			rsq_s2   <= cpot_pkg::RSQ_W'(rsum_s1) * cpot_pkg::RSQ_W'(rsum_s1);
			cp_s2[0] <= da_s1[1] * db_s1[2];
			cp_s2[1] <= da_s1[2] * db_s1[1];
			cp_s2[2] <= da_s1[2] * db_s1[0];
			cp_s2[3] <= da_s1[0] * db_s1[2];
			cp_s2[4] <= da_s1[0] * db_s1[1];
			cp_s2[5] <= da_s1[1] * db_s1[0];
			for (int i = 0; i < 4; i++) begin
				for (int k = 0; k < 3; k++) begin
					psq_s2[i][k] <= pd_s1[i][k] * pd_s1[i][k];
				end
			end
		end
	end

	// stage 3: cross product and endpoint distances
	logic                       v_s3;
	logic [1:0]                 mode_s3;
	logic [PTW-1:0]             a0_s3, a1_s3, b0_s3, b1_s3;
	logic [cpot_pkg::RSQ_W-1:0] rsq_s3;
	logic signed [PW:0]         cr_s3 [3];
	logic [QW-1:0]              pdist_s3 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3 <= mode_s2;
			a0_s3   <= a0_s2;
			a1_s3   <= a1_s2;
			b0_s3   <= b0_s2;
			b1_s3   <= b1_s2;
			rsq_s3  <= rsq_s2;
			for (int k = 0; k < 3; k++) begin
				cr_s3[k] <= (PW + 1)'(cp_s2[2*k]) - (PW + 1)'(cp_s2[2*k+1]);
			end
			for (int i = 0; i < 4; i++) begin
				pdist_s3[i] <= QW'($unsigned(psq_s2[i][0])) + QW'($unsigned(psq_s2[i][1])) +
					QW'($unsigned(psq_s2[i][2]));
			end
		end
	end

	// stage 4: parallel-case pick (earlier pair wins ties), sphere hit
	cpot_pkg::cpot_side_t side_n;
	logic [QW-1:0]        pbest;
	logic [1:0]           pidx;

	always_comb begin
		pbest = pdist_s3[0];
		pidx  = 2'd0;
		for (int i = 1; i < 4; i++) begin
			if (pbest > pdist_s3[i]) begin
				pbest = pdist_s3[i];
				pidx  = 2'(i);
			end
		end
		side_n.mode     = mode_s3;
		side_n.par      = (cr_s3[0] == '0) && (cr_s3[1] == '0) && (cr_s3[2] == '0);
		side_n.hit0     = BW'(pdist_s3[0]) <= BW'(rsq_s3);
		side_n.par_best = BW'(pbest);
		side_n.par_na   = (pidx[1] ? a1_s3 : a0_s3) & PT_MASK;
		side_n.par_nb   = (pidx[0] ? b1_s3 : b0_s3) & PT_MASK;
		side_n.rsq      = rsq_s3;
	end

	// delay line; with side stages 1 to 3 it matches the segment-unit latency
	cpot_pkg::cpot_side_t side_dl [DL+1];
	logic                 v_dl [DL+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_dl[0] <= 1'b0;
		end else if (en) begin
			v_dl[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_dl[0] <= side_n;
		end
	end

	for (genvar j = 0; j < DL; j++) begin : g_dl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dl[j+1] <= 1'b0;
			end else if (en) begin
				v_dl[j+1] <= v_dl[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_dl[j+1] <= side_dl[j];
			end
		end
	end

	// merge 1: A endpoints onto B
	logic                 v_sc1, vb_sc1;
	cpot_pkg::cpot_side_t side_sc1;
	logic [BW-1:0]        best_sc1, d2_sc1, d3_sc1;
	logic [PTW-1:0]       nb_sc1, p2_sc1, p3_sc1;
	logic [BW-1:0]        best1;
	logic [PTW-1:0]       nb1;
	logic                 vb1;

	always_comb begin
		best1 = LIM_SQ;
		nb1   = '0;
		vb1   = 1'b0;
		for (int i = 0; i < 2; i++) begin
			if (best1 > up_d[i]) begin
				best1 = up_d[i];
				nb1   = up_pt[i];
				vb1   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sc1 <= 1'b0;
		end else if (en) begin
			v_sc1 <= v_dl[DL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sc1 <= side_dl[DL];
			best_sc1 <= best1;
			nb_sc1   <= nb1;
			vb_sc1   <= vb1;
			p2_sc1   <= up_pt[2];
			d2_sc1   <= up_d[2];
			p3_sc1   <= up_pt[3];
			d3_sc1   <= up_d[3];
		end
	end

	// merge 2: B endpoints onto A
	logic                 v_sc2, vb_sc2, va_sc2;
	cpot_pkg::cpot_side_t side_sc2;
	logic [BW-1:0]        best_sc2, d2_sc2;
	logic [PTW-1:0]       nb_sc2, na_sc2, p2_sc2;
	logic [BW-1:0]        best2;
	logic [PTW-1:0]       na2;
	logic                 va2;

	always_comb begin
		best2 = best_sc1;
		na2   = '0;
		va2   = 1'b0;
		if (best2 > d2_sc1) begin
			best2 = d2_sc1;
			na2   = p2_sc1;
			va2   = 1'b1;
		end
		if (best2 > d3_sc1) begin
			best2 = d3_sc1;
			na2   = p3_sc1;
			va2   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sc2 <= 1'b0;
		end else if (en) begin
			v_sc2 <= v_sc1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sc2 <= side_sc1;
			best_sc2 <= best2;
			nb_sc2   <= nb_sc1;
			vb_sc2   <= vb_sc1;
			na_sc2   <= na2;
			va_sc2   <= va2;
			p2_sc2   <= p2_sc1;
			d2_sc2   <= d2_sc1;
		end
	end

	// output register: select by mode, final radius compare
	cpot_pkg::cpot_out_t res_n;
	logic [BW-1:0]       rsq_w;

	always_comb begin
		rsq_w = BW'(side_sc2.rsq);
		res_n = '0;
		unique case (side_sc2.mode)
			cpot_pkg::MODE_SPHERE: begin
				res_n.hit = side_sc2.hit0;
			end
			cpot_pkg::MODE_CAP_SPHERE: begin
				res_n.hit          = d2_sc2 <= rsq_w;
				res_n.near_a_valid = 1'b1;
				res_n.near_a       = p2_sc2;
			end
			cpot_pkg::MODE_CAP_CAP: begin
				if (side_sc2.par) begin
					res_n.hit          = side_sc2.par_best <= rsq_w;
					res_n.near_a_valid = 1'b1;
					res_n.near_a       = side_sc2.par_na;
					res_n.near_b_valid = 1'b1;
					res_n.near_b       = side_sc2.par_nb;
				end else begin
					res_n.hit          = best_sc2 <= rsq_w;
					res_n.near_a_valid = va_sc2;
					res_n.near_a       = na_sc2;
					res_n.near_b_valid = vb_sc2;
					res_n.near_b       = nb_sc2;
				end
			end
			default: begin
				res_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= v_sc2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result <= res_n;
		end
	end

endmodule
